// ----- hdl/smab_pkg.sv -----
// smab_pkg: shared constants for the systolic mac array beat block
// no dependencies; used by the channel interfaces and the top level

package smab_pkg;

	// lane count and field width of one beat, fixed by the channel format
	localparam int unsigned LANES   = 8;
	localparam int unsigned FIELD_W = 16;
	// widest internal data word; sign extension goes through this width
	localparam int unsigned EXT_W   = 32;

	// beat kind carried in the func field
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

endpackage

// ----- hdl/smab_beat_if.sv -----
// smab_lane_if / smab_result_if: valid/ready channels of the mac array
// depends on smab_pkg for the field width

interface smab_lane_if;
	logic valid;
	logic ready;
	logic func;
	logic signed [smab_pkg::FIELD_W-1:0] lane_0;
	logic signed [smab_pkg::FIELD_W-1:0] lane_1;
	logic signed [smab_pkg::FIELD_W-1:0] lane_2;
	logic signed [smab_pkg::FIELD_W-1:0] lane_3;
	logic signed [smab_pkg::FIELD_W-1:0] lane_4;
	logic signed [smab_pkg::FIELD_W-1:0] lane_5;
	logic signed [smab_pkg::FIELD_W-1:0] lane_6;
	logic signed [smab_pkg::FIELD_W-1:0] lane_7;

	modport source (output valid, func, lane_0, lane_1, lane_2, lane_3,
		lane_4, lane_5, lane_6, lane_7, input ready);
	modport sink (input valid, func, lane_0, lane_1, lane_2, lane_3,
		lane_4, lane_5, lane_6, lane_7, output ready);
endinterface

interface smab_result_if;
	logic valid;
	logic ready;
	logic signed [smab_pkg::FIELD_W-1:0] col_result_0;
	logic signed [smab_pkg::FIELD_W-1:0] col_result_1;
	logic signed [smab_pkg::FIELD_W-1:0] col_result_2;
	logic signed [smab_pkg::FIELD_W-1:0] col_result_3;
	logic signed [smab_pkg::FIELD_W-1:0] col_result_4;
	logic signed [smab_pkg::FIELD_W-1:0] col_result_5;
	logic signed [smab_pkg::FIELD_W-1:0] col_result_6;
	logic signed [smab_pkg::FIELD_W-1:0] col_result_7;

	modport source (output valid, col_result_0, col_result_1, col_result_2,
		col_result_3, col_result_4, col_result_5, col_result_6, col_result_7,
		input ready);
	modport sink (input valid, col_result_0, col_result_1, col_result_2,
		col_result_3, col_result_4, col_result_5, col_result_6, col_result_7,
		output ready);
endinterface

// ----- hdl/systolic_mac_array_beat_top.sv -----
// systolic_mac_array_beat_top: weight-stationary GRID_SIZE x GRID_SIZE mac grid
// depends on smab_pkg and the channel interfaces in smab_beat_if.sv

// Each accepted beat is either a load beat (func 0: lanes become the new row 0
// weights, all weights shift down one row after this beat's products) or a data
// beat (func 1: lanes drive the column 0 inputs, which are then held through
// later load beats). Every beat yields one result beat with the bottom row's
// column sums, wrapped to DATA_WIDTH bits and sign-extended or truncated to 16;
// columns beyond GRID_SIZE read zero and lanes beyond it are ignored. The block
// takes one beat per clock while the result side is not stalling: a beat is
// registered at the input, all cells do their multiply-add in parallel from
// that input register, and the result lands in the output register.
// Back-pressure on the result side stalls the grid without losing beats. After
// reset weights, partial sums and forwarded inputs are all ones and the column
// 0 inputs are zero.

module systolic_mac_array_beat_top #(
	parameter int unsigned GRID_SIZE  = 8,
	parameter int unsigned DATA_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	smab_lane_if.sink     lanes,
	smab_result_if.source results
);

	localparam int unsigned FW = smab_pkg::FIELD_W;
	localparam int unsigned DW = DATA_WIDTH;
	localparam int unsigned G  = GRID_SIZE;

	// input lanes as an array
	logic signed [FW-1:0] lane_in [smab_pkg::LANES];
	assign lane_in[0] = lanes.lane_0;
	assign lane_in[1] = lanes.lane_1;
	assign lane_in[2] = lanes.lane_2;
	assign lane_in[3] = lanes.lane_3;
	assign lane_in[4] = lanes.lane_4;
	assign lane_in[5] = lanes.lane_5;
	assign lane_in[6] = lanes.lane_6;
	assign lane_in[7] = lanes.lane_7;

	// input stage
	logic                 valid_s1;
	logic                 func_s1;
	logic signed [FW-1:0] lane_s1 [G];

	// grid state
	logic [G-1:0][G-1:0][DW-1:0] w_q;
	logic [G-2:0][G-1:0][DW-1:0] psum_q;
	logic [G-1:0][G-2:0][DW-1:0] fwd_q;
	logic [G-1:0][DW-1:0]        left_q;

	// result register
	logic                 out_valid_q;
	logic signed [FW-1:0] res_q [smab_pkg::LANES];

	logic advance;
	assign advance = valid_s1 && (!out_valid_q || results.ready);
	assign lanes.ready = !valid_s1 || advance;

	// per-cell combinational values
	logic [G-1:0][DW-1:0]        lane_data;
	logic [G-1:0][DW-1:0]        x_edge;
	logic [G-1:0][G-1:0][DW-1:0] xc;
	logic [G-1:0][G-1:0][DW-1:0] sc;
	logic [G-1:0][G-1:0][DW-1:0] res;

	for (genvar i = 0; i < G; i++) begin : g_row
		logic signed [smab_pkg::EXT_W-1:0] lane_ext;
		assign lane_ext     = smab_pkg::EXT_W'(lane_s1[i]);
		assign lane_data[i] = lane_ext[DW-1:0];
		assign x_edge[i]    = (func_s1 == smab_pkg::FUNC_DATA) ? lane_data[i] : left_q[i];

		for (genvar j = 0; j < G; j++) begin : g_col
			if (j == 0) begin : g_edge
				assign xc[i][j] = x_edge[i];
			end else begin : g_fwd
				assign xc[i][j] = fwd_q[i][j-1];
			end
			if (i == 0) begin : g_top
				assign sc[i][j] = '0;
			end else begin : g_below
				assign sc[i][j] = psum_q[i-1][j];
			end
			assign res[i][j] = DW'(w_q[i][j] * xc[i][j]) + sc[i][j];
		end
	end

	// control and grid state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			w_q         <= '1;
			psum_q      <= '1;
			fwd_q       <= '1;
			left_q      <= '0;
		end else begin
			if (lanes.ready) begin
				valid_s1 <= lanes.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				left_q <= x_edge;
				psum_q <= res[G-2:0];
				for (int i = 0; i < G; i++) begin
					for (int j = 0; j < G - 1; j++) begin
						fwd_q[i][j] <= xc[i][j];
					end
				end
				if (func_s1 == smab_pkg::FUNC_LOAD) begin
					w_q[G-1:1] <= w_q[G-2:0];
					w_q[0]     <= lane_data;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (lanes.ready && lanes.valid) begin
			func_s1 <= lanes.func;
			for (int i = 0; i < G; i++) begin
				lane_s1[i] <= lane_in[i];
			end
		end
	end

	for (genvar j = 0; j < smab_pkg::LANES; j++) begin : g_out
		if (j < G) begin : g_live
			logic signed [smab_pkg::EXT_W-1:0] res_ext;
			assign res_ext = smab_pkg::EXT_W'($signed(res[G-1][j]));
			always_ff @(posedge clk) begin
				if (advance) begin
					res_q[j] <= res_ext[FW-1:0];
				end
			end
		end else begin : g_idle
			assign res_q[j] = '0;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.col_result_0 = res_q[0];
	assign results.col_result_1 = res_q[1];
	assign results.col_result_2 = res_q[2];
	assign results.col_result_3 = res_q[3];
	assign results.col_result_4 = res_q[4];
	assign results.col_result_5 = res_q[5];
	assign results.col_result_6 = res_q[6];
	assign results.col_result_7 = res_q[7];

`ifndef SYNTHESIS
	// a beat leaving the input stage always shows up at the output
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> results.valid)
		else $error("advanced beat did not reach the result register");

	// both stages full and output stalled: no new beat may enter
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !results.ready) |-> !lanes.ready)
		else $error("input accepted while pipeline is full");

	// weights hold over data beats and over stalls
	a_weights_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && func_s1 == smab_pkg::FUNC_LOAD) |=> $stable(w_q))
		else $error("weights changed without a load beat");

	// load beat shifts the rows down by one; checked on row 0 moving into row 1
	a_weights_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && func_s1 == smab_pkg::FUNC_LOAD) |=> w_q[1] == $past(w_q[0]))
		else $error("weights did not shift on a load beat");

	// column 0 inputs change only on data beats
	a_left_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && func_s1 == smab_pkg::FUNC_DATA) |=> $stable(left_q))
		else $error("column 0 inputs changed without a data beat");
`endif

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking bench for systolic_mac_array_beat_top, 8x8 grid at 16 bits
// depends on smab_pkg, the channel interfaces and the top level in hdl/
// own cycle model of the grid predicts every result beat not typed in the table

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID  = 8;
	localparam int DATA_W = 16;

	typedef logic signed [smab_pkg::FIELD_W-1:0] word_t;
	typedef logic [0:smab_pkg::LANES-1][smab_pkg::FIELD_W-1:0] lane_vec_t;

	typedef struct packed {
		logic      func;
		lane_vec_t lane;
	} beat_t;

	typedef struct packed {
		logic      func;
		lane_vec_t lane;
		logic      typed;
		lane_vec_t want;
	} stim_row_t;

	localparam int N_DIR = 20;

	// only the first row after reset is typed in: weights and sums all ones,
	// column 0 input zero, so column 0 reads -1 and the rest 1 - 1 = 0
	localparam stim_row_t DIR_TAB [N_DIR] = '{
		'{smab_pkg::FUNC_LOAD, '{8{16'h0000}}, 1'b1, '{16'hFFFF, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
		'{smab_pkg::FUNC_LOAD, '{8{16'h7FFF}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_LOAD, '{8{16'h8000}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_LOAD, '{8{16'hFFFF}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_LOAD, '{8{16'h0001}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_LOAD, '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h8000, 16'h7FFF, 16'h8000}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_LOAD, '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
			16'h0002, 16'hFFFE, 16'h4000}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_LOAD, '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_DATA, '{8{16'h7FFF}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_DATA, '{8{16'h8000}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_DATA, '{8{16'hFFFF}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_DATA, '{16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005,
			16'h0006, 16'h0007, 16'h0008}, 1'b0, '{8{16'h0000}}},
		// load beats with nonzero held column 0 inputs
		'{smab_pkg::FUNC_LOAD, '{16'h1234, 16'h8001, 16'h7FFE, 16'h00FF, 16'hFF00,
			16'h0F0F, 16'hF0F0, 16'h0000}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_LOAD, '{8{16'h0100}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_DATA, '{8{16'h0000}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_DATA, '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
			16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_DATA, '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_LOAD, '{8{16'h8000}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_DATA, '{8{16'h7FFF}}, 1'b0, '{8{16'h0000}}},
		'{smab_pkg::FUNC_DATA, '{8{16'h8000}}, 1'b0, '{8{16'h0000}}}
	};

	logic clk;
	logic arst_n;

	smab_lane_if   lanes_if ();
	smab_result_if results_if ();

	systolic_mac_array_beat_top #(
		.GRID_SIZE  (GRID),
		.DATA_WIDTH (DATA_W)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.lanes   (lanes_if),
		.results (results_if)
	);

	// grid model state
	word_t cell_w [GRID][GRID];
	word_t sum_down [GRID-1][GRID];
	word_t x_right [GRID][GRID-1];
	word_t x_left [GRID];

	lane_vec_t pending_rows [$];
	int        err_cnt = 0;
	int        rows_seen = 0;
	int        hold_left = 0;
	int        send_idle_pct = 9;
	int        rcv_idle_pct = 84;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// one beat of the grid: products from the old state, then registers move
	function automatic lane_vec_t mac_grid_step(input beat_t b);
		word_t     sum_now [GRID][GRID];
		word_t     x_now [GRID][GRID];
		word_t     s;
		lane_vec_t bottom;
		if (b.func == smab_pkg::FUNC_DATA) begin
			for (int i = 0; i < GRID; i++)
				x_left[i] = b.lane[i];
		end
		for (int i = 0; i < GRID; i++) begin
			for (int j = 0; j < GRID; j++) begin
				x_now[i][j] = (j == 0) ? x_left[i] : x_right[i][j-1];
				s = (i == 0) ? word_t'(0) : sum_down[i-1][j];
				sum_now[i][j] = cell_w[i][j] * x_now[i][j] + s;
			end
		end
		for (int i = 0; i < GRID - 1; i++)
			for (int j = 0; j < GRID; j++)
				sum_down[i][j] = sum_now[i][j];
		for (int i = 0; i < GRID; i++)
			for (int j = 0; j < GRID - 1; j++)
				x_right[i][j] = x_now[i][j];
		if (b.func == smab_pkg::FUNC_LOAD) begin
			for (int i = GRID - 1; i > 0; i--)
				for (int j = 0; j < GRID; j++)
					cell_w[i][j] = cell_w[i-1][j];
			for (int j = 0; j < GRID; j++)
				cell_w[0][j] = b.lane[j];
		end
		bottom = '0;
		for (int j = 0; j < GRID; j++)
			bottom[j] = sum_now[GRID-1][j];
		return bottom;
	endfunction

	// extremes and small values show up often, the rest is full range
	function automatic lane_vec_t rand_lanes();
		lane_vec_t v;
		for (int j = 0; j < smab_pkg::LANES; j++) begin
			case ($urandom_range(9))
				0: v[j] = 16'h0000;
				1: v[j] = 16'h7FFF;
				2: v[j] = 16'h8000;
				3: v[j] = 16'hFFFF;
				4: v[j] = 16'h0001;
				5: v[j] = 16'($signed($urandom_range(0, 15)) - 8);
				default: v[j] = 16'($urandom);
			endcase
		end
		return v;
	endfunction

	task automatic send_beat(input beat_t b, input logic typed, input lane_vec_t want);
		lane_vec_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			lanes_if.valid <= 1'b0;
			@(posedge clk);
		end
		lanes_if.valid  <= 1'b1;
		lanes_if.func   <= b.func;
		lanes_if.lane_0 <= b.lane[0];
		lanes_if.lane_1 <= b.lane[1];
		lanes_if.lane_2 <= b.lane[2];
		lanes_if.lane_3 <= b.lane[3];
		lanes_if.lane_4 <= b.lane[4];
		lanes_if.lane_5 <= b.lane[5];
		lanes_if.lane_6 <= b.lane[6];
		lanes_if.lane_7 <= b.lane[7];
		@(posedge clk);
		while (lanes_if.ready !== 1'b1)
			@(posedge clk);
		pred = mac_grid_step(b);
		pending_rows.push_back(typed ? want : pred);
	endtask

	// mostly full weight loads followed by data runs, some short loads and noise
	task automatic run_random(input int n_beats);
		int    sent;
		int    run_len;
		int    n_load;
		beat_t b;
		sent = 0;
		while (sent < n_beats) begin
			case ($urandom_range(9))
				0, 1: begin
					run_len = $urandom_range(1, 6);
					for (int k = 0; k < run_len; k++) begin
						b.func = 1'($urandom_range(1));
						b.lane = rand_lanes();
						send_beat(b, 1'b0, '0);
						sent++;
					end
				end
				default: begin
					n_load = ($urandom_range(9) == 0) ? $urandom_range(1, GRID - 1) : GRID;
					for (int k = 0; k < n_load; k++) begin
						b.func = smab_pkg::FUNC_LOAD;
						b.lane = rand_lanes();
						send_beat(b, 1'b0, '0);
						sent++;
					end
					run_len = $urandom_range(1, 24);
					for (int k = 0; k < run_len; k++) begin
						b.func = smab_pkg::FUNC_DATA;
						b.lane = rand_lanes();
						send_beat(b, 1'b0, '0);
						sent++;
					end
				end
			endcase
		end
	endtask

	// result side: check each beat, then pick next cycle's ready
	always @(posedge clk or negedge arst_n) begin
		lane_vec_t got;
		lane_vec_t want;
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
				got = {results_if.col_result_0, results_if.col_result_1,
					results_if.col_result_2, results_if.col_result_3,
					results_if.col_result_4, results_if.col_result_5,
					results_if.col_result_6, results_if.col_result_7};
				if (pending_rows.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result beat %0d: got %h", rows_seen, got);
				end else begin
					want = pending_rows.pop_front();
					for (int j = 0; j < smab_pkg::LANES; j++) begin
						if (got[j] !== want[j]) begin
							err_cnt++;
							if (err_cnt <= 10)
								$display("result beat %0d col %0d: expected %h got %h",
									rows_seen, j, want[j], got[j]);
						end
					end
				end
				rows_seen++;
				// long back-pressure so the grid fills and stalls its input
				if (rows_seen == 300 || rows_seen == 1400)
					hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	initial begin
		beat_t b;
		arst_n          <= 1'b0;
		lanes_if.valid  <= 1'b0;
		lanes_if.func   <= smab_pkg::FUNC_LOAD;
		lanes_if.lane_0 <= '0;
		lanes_if.lane_1 <= '0;
		lanes_if.lane_2 <= '0;
		lanes_if.lane_3 <= '0;
		lanes_if.lane_4 <= '0;
		lanes_if.lane_5 <= '0;
		lanes_if.lane_6 <= '0;
		lanes_if.lane_7 <= '0;
		for (int i = 0; i < GRID; i++) begin
			x_left[i] = '0;
			for (int j = 0; j < GRID; j++)
				cell_w[i][j] = '1;
			for (int j = 0; j < GRID - 1; j++)
				x_right[i][j] = '1;
		end
		for (int i = 0; i < GRID - 1; i++)
			for (int j = 0; j < GRID; j++)
				sum_down[i][j] = '1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			b.func = DIR_TAB[r].func;
			b.lane = DIR_TAB[r].lane;
			send_beat(b, DIR_TAB[r].typed, DIR_TAB[r].want);
		end
		run_random(583);

		send_idle_pct = 84;
		rcv_idle_pct  = 9;
		run_random(583);

		send_idle_pct = 0;
		rcv_idle_pct  = 0;
		run_random(584);
		lanes_if.valid <= 1'b0;

		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (err_cnt == 0 && pending_rows.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
